>>> sv/rukq_pkg.sv
package rukq_pkg;

	// default sizes for the top level
	localparam int DEPTH_DEF      = 16;
	localparam int NAME_CHARS_DEF = 3;
	localparam int SCORE_BITS_DEF = 16;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FIND_RD,
		ST_FIND_CHK,
		ST_DEL_RD,
		ST_DEL_WR,
		ST_POS_RD,
		ST_POS_CHK,
		ST_POS_SET,
		ST_INS_RD,
		ST_INS_WR,
		ST_PUT,
		ST_POP_RD,
		ST_POP_GET,
		ST_DONE
	} rukq_state_t;

	// opcodes
	typedef enum logic {
		OP_ADD = 1'b0,
		OP_POP = 1'b1
	} rukq_op_t;

	// result of the shared rank comparator
	typedef struct packed {
		logic name_eq;  // names identical
		logic ahead;    // entry a ranks ahead of entry b
	} rukq_cmp_t;

endpackage

>>> sv/rukq_table.sv
module rukq_table
	import rukq_pkg::*;
#(
	parameter int DEPTH   = DEPTH_DEF,
	parameter int NAME_W  = NAME_CHARS_DEF * 8,
	parameter int SCORE_W = SCORE_BITS_DEF,
	localparam int IDX_W  = $clog2(DEPTH)
) (
	input  logic               clk,
	input  logic               wr_en,
	input  logic [IDX_W-1:0]   wr_addr,
	input  logic [NAME_W-1:0]  wr_name,
	input  logic [SCORE_W-1:0] wr_score,
	input  logic               rd_en,
	input  logic [IDX_W-1:0]   rd_addr,
	output logic [NAME_W-1:0]  rd_name,
	output logic [SCORE_W-1:0] rd_score
);

	// ranked entries, slot 0 is the top
	logic [NAME_W-1:0]  name_mem  [DEPTH];
	logic [SCORE_W-1:0] score_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			name_mem[wr_addr]  <= wr_name;
			score_mem[wr_addr] <= wr_score;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_name  <= name_mem[rd_addr];
			rd_score <= score_mem[rd_addr];
		end
	end

endmodule

>>> sv/rukq_cmp.sv
module rukq_cmp
	import rukq_pkg::*;
#(
	parameter int NAME_W  = NAME_CHARS_DEF * 8,
	parameter int SCORE_W = SCORE_BITS_DEF
) (
	input  logic [NAME_W-1:0]  a_name,
	input  logic [SCORE_W-1:0] a_score,
	input  logic [NAME_W-1:0]  b_name,
	input  logic [SCORE_W-1:0] b_score,
	output rukq_cmp_t          res
);

	// higher score first; on a tie the smaller name (first byte most significant)
	always_comb begin
		res.name_eq = (a_name == b_name);
		if (a_score != b_score) begin
			res.ahead = (a_score > b_score);
		end else begin
			res.ahead = (a_name < b_name);
		end
	end

endmodule

>>> sv/ranked_unique_key_queue.sv
// Ranked unique-key queue. Holds up to DEPTH entries, each a name of NAME_CHARS
// bytes (first character in the top byte) and a SCORE_BITS score, kept in rank
// order: higher score first, equal scores by ascending name. A name ends at its
// first zero byte; later bytes are cleared before storing. opcode 0 adds a name
// or, if already held, keeps the larger score and re-ranks it; adding a new name
// to a full table drops the lowest of the DEPTH+1 entries (possibly the new one)
// and sets dropped. opcode 1 pops the top entry; popping an empty table returns
// pop_valid 0. Each input transaction yields exactly one output transaction.
// Entries sit in a single-port-read, single-port-write table with registered
// read, walked by a sequencer that shares one rank comparator. An add runs a
// search plus removal over the table, then a placement search plus shift; a
// pop reads the top entry and shifts the rest up (nothing on an empty table).
// A finished result first waits for the output register to free. The input is
// not ready while a transaction is being worked; a finished result then waits
// in the output register, and the next input is taken while it waits.
module ranked_unique_key_queue
	import rukq_pkg::*;
#(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int NAME_CHARS = NAME_CHARS_DEF,
	parameter int SCORE_BITS = SCORE_BITS_DEF,
	localparam int NAME_W    = NAME_CHARS * 8,
	localparam int CNT_W     = $clog2(DEPTH + 1),
	localparam int IN_W      = ((NAME_W + SCORE_BITS + 7) / 8) * 8,
	localparam int OUT_RAW   = NAME_W + SCORE_BITS + CNT_W + 2,
	localparam int OUT_W     = ((OUT_RAW + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [IN_W-1:0]  s_axis_tdata,   // entry_name, entry_score, zero pad
	input  logic             s_axis_tuser,   // opcode
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [OUT_W-1:0] m_axis_tdata,   // pop_name, pop_score, entry_count,
	                                         // is_empty, dropped, zero pad
	output logic             m_axis_tuser    // pop_valid
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
	localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

	rukq_state_t state_q, state_d;

	// transaction being worked
	rukq_op_t             op_q;
	logic [NAME_W-1:0]    key_name_q;
	logic [SCORE_BITS-1:0] key_score_q;

	// walk index, placement slot and fill count
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] pos_q;
	logic [CNT_W-1:0] cnt_q;

	// result under construction
	logic                  drop_q;
	logic                  pv_q;
	logic [NAME_W-1:0]     pn_q;
	logic [SCORE_BITS-1:0] ps_q;

	// output register
	logic                  m_valid_q;
	logic                  m_pv_q;
	logic [NAME_W-1:0]     m_name_q;
	logic [SCORE_BITS-1:0] m_score_q;
	logic [CNT_W-1:0]      m_cnt_q;
	logic                  m_drop_q;

	// table ports
	logic                  wr_en;
	logic [CNT_W-1:0]      wr_addr;
	logic [NAME_W-1:0]     wr_name;
	logic [SCORE_BITS-1:0] wr_score;
	logic                  rd_en;
	logic [CNT_W-1:0]      rd_addr;
	logic [NAME_W-1:0]     rd_name;
	logic [SCORE_BITS-1:0] rd_score;

	rukq_cmp_t cmp;

	logic                  s_fire;
	logic                  out_free;
	logic [CNT_W-1:0]      idx_inc;
	logic [CNT_W-1:0]      idx_dec;
	logic [NAME_W-1:0]     in_name;
	logic [NAME_W-1:0]     clean_name;
	logic [7:0]            name_byte;
	logic                  alive;

	assign s_fire   = s_axis_tvalid & s_axis_tready;
	assign out_free = ~m_valid_q | m_axis_tready;
	assign idx_inc  = idx_q + ONE_C;
	assign idx_dec  = idx_q - ONE_C;
	assign in_name  = s_axis_tdata[NAME_W-1:0];

	// clear every byte from the first zero byte on, scanning from the first char
	always_comb begin
		alive      = 1'b1;
		name_byte  = '0;
		clean_name = '0;
		for (int i = NAME_CHARS - 1; i >= 0; i--) begin
			name_byte = in_name[i*8 +: 8];
			if (name_byte == 8'd0) begin
				alive = 1'b0;
			end
			clean_name[i*8 +: 8] = alive ? name_byte : 8'd0;
		end
	end

	rukq_table #(
		.DEPTH   (DEPTH),
		.NAME_W  (NAME_W),
		.SCORE_W (SCORE_BITS)
	) u_table (
		.clk      (clk),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr[IDX_W-1:0]),
		.wr_name  (wr_name),
		.wr_score (wr_score),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr[IDX_W-1:0]),
		.rd_name  (rd_name),
		.rd_score (rd_score)
	);

	// one comparator: held key against the entry just read
	rukq_cmp #(
		.NAME_W  (NAME_W),
		.SCORE_W (SCORE_BITS)
	) u_cmp (
		.a_name  (key_name_q),
		.a_score (key_score_q),
		.b_name  (rd_name),
		.b_score (rd_score),
		.res     (cmp)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_fire) begin
					if (rukq_op_t'(s_axis_tuser) == OP_POP) begin
						state_d = (cnt_q == '0) ? ST_DONE : ST_POP_RD;
					end else begin
						state_d = (cnt_q == '0) ? ST_POS_SET : ST_FIND_RD;
					end
				end
			end
			ST_FIND_RD:  state_d = ST_FIND_CHK;
			ST_FIND_CHK: begin
				if (cmp.name_eq) begin
					state_d = ST_DEL_RD;
				end else if (idx_inc < cnt_q) begin
					state_d = ST_FIND_RD;
				end else begin
					state_d = ST_POS_RD;
				end
			end
			ST_DEL_RD: begin
				if (idx_inc < cnt_q) begin
					state_d = ST_DEL_WR;
				end else if (op_q == OP_POP) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_POS_RD;
				end
			end
			ST_DEL_WR:  state_d = ST_DEL_RD;
			ST_POS_RD:  state_d = (idx_q < cnt_q) ? ST_POS_CHK : ST_POS_SET;
			ST_POS_CHK: state_d = cmp.ahead ? ST_POS_SET : ST_POS_RD;
			ST_POS_SET: begin
				if (cnt_q == DEPTH_C && idx_q == DEPTH_C) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_INS_RD;
				end
			end
			ST_INS_RD:  state_d = (idx_q > pos_q) ? ST_INS_WR : ST_PUT;
			ST_INS_WR:  state_d = ST_INS_RD;
			ST_PUT:     state_d = ST_DONE;
			ST_POP_RD:  state_d = ST_POP_GET;
			ST_POP_GET: state_d = ST_DEL_RD;
			ST_DONE:    state_d = out_free ? ST_IDLE : ST_DONE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// table control
	always_comb begin
		rd_en    = 1'b0;
		rd_addr  = idx_q;
		wr_en    = 1'b0;
		wr_addr  = idx_q;
		wr_name  = rd_name;
		wr_score = rd_score;
		unique case (state_q)
			ST_FIND_RD: rd_en = 1'b1;
			ST_DEL_RD: begin
				rd_en   = (idx_inc < cnt_q);
				rd_addr = idx_inc;
			end
			ST_DEL_WR: wr_en = 1'b1;
			ST_POS_RD: rd_en = (idx_q < cnt_q);
			ST_INS_RD: begin
				rd_en   = (idx_q > pos_q);
				rd_addr = idx_dec;
			end
			ST_INS_WR: wr_en = 1'b1;
			ST_PUT: begin
				wr_en    = 1'b1;
				wr_addr  = pos_q;
				wr_name  = key_name_q;
				wr_score = key_score_q;
			end
			ST_POP_RD: begin
				rd_en   = 1'b1;
				rd_addr = '0;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			idx_q  <= '0;
			pos_q  <= '0;
			drop_q <= 1'b0;
			pv_q   <= 1'b0;
			op_q   <= OP_ADD;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_fire) begin
						op_q   <= rukq_op_t'(s_axis_tuser);
						idx_q  <= '0;
						drop_q <= 1'b0;
						pv_q   <= 1'b0;
					end
				end
				ST_FIND_CHK: begin
					if (!cmp.name_eq) begin
						idx_q <= (idx_inc < cnt_q) ? idx_inc : '0;
					end
				end
				ST_DEL_RD: begin
					if (!(idx_inc < cnt_q)) begin
						cnt_q <= cnt_q - ONE_C;
						idx_q <= '0;
					end
				end
				ST_DEL_WR:  idx_q <= idx_inc;
				ST_POS_CHK: begin
					if (!cmp.ahead) begin
						idx_q <= idx_inc;
					end
				end
				ST_POS_SET: begin
					pos_q <= idx_q;
					if (cnt_q == DEPTH_C) begin
						// full: the lowest of the DEPTH+1 entries falls off;
						// a newcomer ranked last leaves the table as it is
						drop_q <= 1'b1;
						if (idx_q != DEPTH_C) begin
							cnt_q <= DEPTH_C - ONE_C;
							idx_q <= DEPTH_C - ONE_C;
						end
					end else begin
						idx_q <= cnt_q;
					end
				end
				ST_INS_WR:  idx_q <= idx_dec;
				ST_PUT:     cnt_q <= cnt_q + ONE_C;
				ST_POP_GET: pv_q <= 1'b1;
				default: begin
					idx_q <= idx_q;
				end
			endcase
		end
	end

	// key and popped payload
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (s_fire) begin
					key_name_q  <= clean_name;
					key_score_q <= s_axis_tdata[NAME_W +: SCORE_BITS];
					pn_q        <= '0;
					ps_q        <= '0;
				end
			end
			ST_FIND_CHK: begin
				// same name: keep the larger score
				if (cmp.name_eq && !cmp.ahead) begin
					key_score_q <= rd_score;
				end
			end
			ST_POP_GET: begin
				pn_q <= rd_name;
				ps_q <= rd_score;
			end
			default: begin
				pn_q <= pn_q;
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			m_pv_q    <= pv_q;
			m_name_q  <= pn_q;
			m_score_q <= ps_q;
			m_cnt_q   <= cnt_q;
			m_drop_q  <= drop_q;
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = m_pv_q;
	assign m_axis_tdata  = OUT_W'({m_drop_q, (m_cnt_q == '0), m_cnt_q, m_score_q, m_name_q});

	// checks
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= DEPTH_C)
		else $error("fill count above depth");

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire |=> !s_axis_tready)
		else $error("input ready straight after a transaction");

	a_pop_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && m_pv_q) |-> !m_drop_q)
		else $error("pop result flagged as dropped");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && m_drop_q) |-> (m_cnt_q == DEPTH_C))
		else $error("drop reported on a table that is not full");

endmodule
